### design/sorted_table_insert_remove_assert.svh
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_assert.svh
// Assertion macros shared by the sorted table design.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INSERT_REMOVE_ASSERT_SVH
`define SORTED_TABLE_INSERT_REMOVE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define STIR_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("sorted table invariant violated");

// A condition that must hold in the cycle after the trigger.
`define STIR_ASSERT_NEXT(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("sorted table sequencing violated");

`endif

### design/stir_pkg.sv
// ----------------------------------------------------------------------------
// stir_pkg
// Types and constants of the sorted table block.
// ----------------------------------------------------------------------------
`default_nettype none

package stir_pkg;

   localparam int VALUE_W  = 32;
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 3;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 4;

   // Request operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_BAD_INDEX = 2'd3
   } status_type;

   // Command broadcast from the control logic to every cell.
   typedef struct packed {
      logic                      ins_en;
      logic                      rem_en;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

`default_nettype wire

### design/stir_req_if.sv
// ----------------------------------------------------------------------------
// stir_req_if
// Request channel: valid/ready handshake with op, value and index.
// ----------------------------------------------------------------------------
`default_nettype none

interface stir_req_if
   import stir_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic signed [VALUE_W-1:0] value;
   logic [INDEX_W-1:0]        index;

   modport source (output valid, op, value, index, input ready);
   modport sink   (input valid, op, value, index, output ready);
endinterface

`default_nettype wire

### design/stir_rsp_if.sv
// ----------------------------------------------------------------------------
// stir_rsp_if
// Result channel: valid/ready handshake with status, occupancy and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface stir_rsp_if
   import stir_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic [OCC_W-1:0]          occupancy;
   logic signed [VALUE_W-1:0] read_value;

   modport source (output valid, status, occupancy, read_value, input ready);
   modport sink   (input valid, status, occupancy, read_value, output ready);
endinterface

`default_nettype wire

### design/stir_cell.sv
// ----------------------------------------------------------------------------
// stir_cell
// One table position: holds an entry, compares it with the request value
// and takes its own, its left or its right neighbor's entry or the new value.
// ----------------------------------------------------------------------------
`default_nettype none

module stir_cell
   import stir_pkg::*;
(
   input  wire logic                      clock,
   input  wire cell_cmd_type              cmd,
   input  wire logic                      entry_valid,
   input  wire logic                      entry_tail,
   input  wire logic signed [VALUE_W-1:0] left_value,
   input  wire logic                      left_ge,
   input  wire logic signed [VALUE_W-1:0] right_value,
   output      logic signed [VALUE_W-1:0] entry_value,
   output      logic                      entry_ge,
   output      logic                      entry_eq
);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   // Local compares; an empty position never matches.
   assign entry_ge    = entry_valid && (value_ff >= cmd.value);
   assign entry_eq    = entry_valid && (value_ff == cmd.value);
   assign entry_value = value_ff;

   // Insert shifts right from the first entry not below the value and drops
   // the value into the gap; remove shifts left from the first equal entry.
   always_comb begin
      value_in = value_ff;
      priority if (cmd.ins_en && left_ge) begin
         value_in = left_value;
      end else if (cmd.ins_en && (entry_ge || entry_tail)) begin
         value_in = cmd.value;
      end else if (cmd.rem_en && entry_ge) begin
         value_in = right_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

### design/sorted_table_insert_remove.sv
// The result of a request is registered at the edge that transfers the request.
// Throughput: one request per cycle unless rsp_chan stalls; cells update in parallel.
// A new request transfers in the same cycle as the held result, so there are no gaps.
// Reset (synchronous) empties the table and drops any pending result; the stored
// entries themselves are not cleared.
// ----------------------------------------------------------------------------
// sorted_table_insert_remove
// Bounded ascending table of signed values built from a row of compare and
// shift cells, with insert, remove-first-equal and read-by-index requests.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_insert_remove
   import stir_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   stir_req_if.sink    req_chan,
   stir_rsp_if.source  rsp_chan
);

   `include "sorted_table_insert_remove_assert.svh"

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int CMP_W  = (FILL_W > INDEX_W) ? FILL_W : INDEX_W;
   localparam int RD_N   = (DEPTH < (1 << INDEX_W)) ? DEPTH : (1 << INDEX_W);

   logic [FILL_W-1:0]         fill_ff;
   logic [FILL_W-1:0]         fill_in;
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       status_ff;
   logic [STATUS_W-1:0]       status_in;
   logic [OCC_W-1:0]          occ_ff;
   logic [OCC_W-1:0]          occ_in;
   logic signed [VALUE_W-1:0] rd_ff;
   logic signed [VALUE_W-1:0] rd_in;

   logic                      req_fire;
   logic                      full;
   logic                      found;
   logic                      index_ok;
   logic signed [VALUE_W-1:0] rd_sel;
   logic [FILL_W+OCC_W-1:0]   fill_ext;
   cell_cmd_type              cmd;

   logic signed [VALUE_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]          cell_ge;
   logic [DEPTH-1:0]          cell_eq;
   logic [DEPTH-1:0]          cell_valid;
   logic [DEPTH-1:0]          cell_tail;

   // Handshake: the output register frees up when its result is transferred.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign full     = (fill_ff == FILL_W'(DEPTH));
   assign found    = |cell_eq;
   assign index_ok = (CMP_W'(req_chan.index) < CMP_W'(fill_ff));

   // Command broadcast to the cell row.
   always_comb begin
      cmd.value  = req_chan.value;
      cmd.ins_en = req_fire && (req_chan.op == OP_INSERT) && !full;
      cmd.rem_en = req_fire && (req_chan.op == OP_REMOVE) && found;
   end

   // Row of cells, each linked to its neighbors; an end cell uses its own entry instead.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_valid[i] = (CMP_W'(i) < CMP_W'(fill_ff));
      assign cell_tail[i]  = (CMP_W'(i) == CMP_W'(fill_ff));

      if (i == 0) begin : g_first
         stir_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .entry_valid (cell_valid[i]),
            .entry_tail  (cell_tail[i]),
            .left_value  (cell_value[i]),
            .left_ge     (1'b0),
            .right_value (cell_value[i+1]),
            .entry_value (cell_value[i]),
            .entry_ge    (cell_ge[i]),
            .entry_eq    (cell_eq[i])
         );
      end else if (i == DEPTH - 1) begin : g_last
         stir_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .entry_valid (cell_valid[i]),
            .entry_tail  (cell_tail[i]),
            .left_value  (cell_value[i-1]),
            .left_ge     (cell_ge[i-1]),
            .right_value (cell_value[i]),
            .entry_value (cell_value[i]),
            .entry_ge    (cell_ge[i]),
            .entry_eq    (cell_eq[i])
         );
      end else begin : g_mid
         stir_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .entry_valid (cell_valid[i]),
            .entry_tail  (cell_tail[i]),
            .left_value  (cell_value[i-1]),
            .left_ge     (cell_ge[i-1]),
            .right_value (cell_value[i+1]),
            .entry_value (cell_value[i]),
            .entry_ge    (cell_ge[i]),
            .entry_eq    (cell_eq[i])
         );
      end
   end

   // Read select over the positions the index can reach.
   always_comb begin
      rd_sel = '0;
      for (int k = 0; k < RD_N; k++) begin
         if (req_chan.index == INDEX_W'(k)) begin
            rd_sel = cell_value[k];
         end
      end
   end

   // Occupancy and result for the request being transferred.
   always_comb begin
      fill_in   = fill_ff;
      status_in = STATUS_OK;
      rd_in     = '0;
      unique case (req_chan.op)
         OP_INSERT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end
         OP_REMOVE: begin
            if (found) begin
               fill_in = fill_ff - FILL_W'(1);
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         OP_READ: begin
            if (index_ok) begin
               rd_in = rd_sel;
            end else begin
               status_in = STATUS_BAD_INDEX;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
      fill_ext = {{OCC_W{1'b0}}, fill_in};
      occ_in   = fill_ext[OCC_W-1:0];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            fill_ff <= fill_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_in;
         occ_ff    <= occ_in;
         rd_ff     <= rd_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.occupancy  = occ_ff;
   assign rsp_chan.read_value = rd_ff;

   // Checks on occupancy tracking and result sequencing.
   `STIR_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FILL_W'(DEPTH))
   `STIR_ASSERT_NEXT(a_rsp_follows_req, clock, reset, req_fire, rsp_valid_ff)
   `STIR_ASSERT_NEXT(a_fill_idle_stable, clock, reset, !req_fire, $stable(fill_ff))

endmodule

`default_nettype wire
